>>> design/mpmd_pkg.sv
// Shared types, constants and tables of the mean power / maximum demand unit.
package mpmd_pkg;

  localparam int unsigned CHANNELS          = 4;
  localparam int unsigned CH_IDX_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned INTERVAL_REGS     = 4;
  localparam int unsigned CFG_IDX_W         = 3;

  localparam logic [7:0]  MINUTE_UNSET      = 8'hFF;
  localparam logic [7:0]  MINUTES_PER_HOUR  = 8'd60;
  localparam logic [7:0]  RESYNC_MINUTE_VAL = 8'd1;
  localparam logic [4:0]  RESYNC_HOUR       = 5'd4;
  localparam logic [5:0]  RESYNC_MINUTE     = 6'd1;

  // Divide by 1000 as a shift by 3 then a divide by 125. The shifted value is split at
  // bit 17: 2^17 = 125 * 1048 + 72, and the small remainder goes through a reciprocal.
  localparam int unsigned DIV_PRESHIFT      = 3;
  localparam int unsigned DIV_SPLIT         = 17;
  localparam logic [10:0] SPLIT_QUOT        = 11'd1048;
  localparam logic [6:0]  SPLIT_REM         = 7'd72;
  localparam logic [23:0] RECIP_125         = 24'd8589935;
  localparam int unsigned RECIP_SHIFT       = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 3'd0,
    REG_INTERVAL_0  = 3'd1,
    REG_INTERVAL_1  = 3'd2,
    REG_INTERVAL_2  = 3'd3,
    REG_INTERVAL_3  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_REPORT,
    ACT_CLEAR,
    ACT_COMPUTE,
    ACT_OUT_OF_RANGE
  } action_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } stamp_t;

  localparam stamp_t STAMP_CLEAR = '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                                     minute: 6'd0};

  typedef struct packed {
    logic [1:0]  channel;
    logic        first_of_minute;
    logic [31:0] count;
    logic        clear_max;
    stamp_t      stamp;
  } item_t;

  // One bit per minute counter value, set where the value is a multiple of step.
  function automatic logic [255:0] multiple_mask(input int unsigned step);
    logic [255:0] mask;
    mask = '0;
    for (int unsigned i = 0; i < 256; i += step) begin
      mask[i] = 1'b1;
    end
    return mask;
  endfunction

  localparam logic [255:0] MULT_MASK_5  = multiple_mask(5);
  localparam logic [255:0] MULT_MASK_10 = multiple_mask(10);
  localparam logic [255:0] MULT_MASK_15 = multiple_mask(15);
  localparam logic [255:0] MULT_MASK_20 = multiple_mask(20);
  localparam logic [255:0] MULT_MASK_30 = multiple_mask(30);
  localparam logic [255:0] MULT_MASK_60 = multiple_mask(60);

endpackage

>>> design/mean_power_max_demand_unit.sv
// Top level of the mean power / maximum demand unit for the energy counter channels.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------------------
//  cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//  item     | in        | item_valid / item_ready   | channel, count, flags, wall clock
//  result   | out       | result_valid / result_ready | mean, maximum and its time, flags
//
// One transaction per cycle in each direction while the output register is not held full.
// Minute counter and last count are updated in the first stage, scaling and the divide by
// 1000 take three stages, and the mean/maximum stores are updated in the last stage before
// the output register. All stages hold together while the output register is full and not taken.
// Reset is synchronous and clears every store; cfg_ready is always high.
module mean_power_max_demand_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [1:0]                     channel,
  input  logic                           first_of_minute,
  input  logic [31:0]                    count,
  input  logic                           clear_max,
  input  logic [5:0]                     clock_minute,
  input  logic [4:0]                     clock_hour,
  input  logic [4:0]                     clock_day,
  input  logic [3:0]                     clock_month,
  input  logic [6:0]                     clock_year,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [15:0]                    mean_power,
  output logic [15:0]                    max_power,
  output logic [6:0]                     max_year,
  output logic [3:0]                     max_month,
  output logic [4:0]                     max_day,
  output logic [4:0]                     max_hour,
  output logic [5:0]                     max_minute,
  output logic                           new_max,
  output logic                           cleared
);
  import mpmd_pkg::*;

  // configuration
  logic [3:0]  enable_mask;
  logic [7:0]  interval [INTERVAL_REGS];

  // state
  logic [7:0]  minute_counter;
  logic [31:0] last_count [CHANNELS];
  logic [15:0] mean_store [CHANNELS];
  logic [15:0] max_store  [CHANNELS];
  stamp_t      max_stamp  [CHANNELS];

  logic advance;

  // stage registers
  logic                s0_valid;
  item_t               s0_item;
  logic                s1_valid, s2_valid, s3_valid, s4_valid;
  action_t             s1_action, s2_action, s3_action, s4_action;
  logic [CH_IDX_W-1:0] s1_ch, s2_ch, s3_ch, s4_ch;
  stamp_t              s1_stamp, s2_stamp, s3_stamp, s4_stamp;
  logic [31:0]         s1_diff;
  logic [3:0]          s1_mult;
  logic [35:0]         s2_prod;
  logic [15:0]         s3_quot_hi;
  logic [22:0]         s3_rem;
  logic [15:0]         s4_mean;

  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      for (int i = 0; i < INTERVAL_REGS; i++) begin
        interval[i] <= 8'd60;
      end
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE_MASK: enable_mask <= cfg_data[3:0];
        REG_INTERVAL_0:  interval[0] <= cfg_data;
        REG_INTERVAL_1:  interval[1] <= cfg_data;
        REG_INTERVAL_2:  interval[2] <= cfg_data;
        REG_INTERVAL_3:  interval[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_item <= '{channel: channel, first_of_minute: first_of_minute, count: count,
                   clear_max: clear_max,
                   stamp: '{year: clock_year, month: clock_month, day: clock_day,
                            hour: clock_hour, minute: clock_minute}};
    end
  end

  // Stage 1: minute counter, priming, interval check and counter difference
  logic [CH_IDX_W-1:0] ch_idx;
  logic                in_range;
  logic [7:0]          minute_inc;
  logic [7:0]          minute_adv;
  logic [7:0]          minute_next;
  logic [7:0]          n;
  logic [3:0]          mult;
  logic                due;
  logic [31:0]         last_cur;
  logic [31:0]         last_next;
  logic                last_we;
  action_t             action;

  assign ch_idx     = CH_IDX_W'(s0_item.channel);
  assign in_range   = 32'(s0_item.channel) < CHANNELS;
  assign minute_inc = minute_counter + 8'd1;
  assign n          = interval[s0_item.channel];
  assign last_cur   = in_range ? last_count[ch_idx] : '0;

  always_comb begin
    if (!s0_item.first_of_minute) begin
      minute_adv = minute_counter;
    end else if (minute_counter == MINUTE_UNSET) begin
      minute_adv = {2'b00, s0_item.stamp.minute};
    end else if (minute_inc >= MINUTES_PER_HOUR) begin
      minute_adv = '0;
    end else begin
      minute_adv = minute_inc;
    end
  end

  // Unlisted intervals run as hourly
  always_comb begin
    case (n)
      8'd5:    begin mult = 4'd12; due = MULT_MASK_5[minute_adv];  end
      8'd10:   begin mult = 4'd6;  due = MULT_MASK_10[minute_adv]; end
      8'd15:   begin mult = 4'd4;  due = MULT_MASK_15[minute_adv]; end
      8'd20:   begin mult = 4'd3;  due = MULT_MASK_20[minute_adv]; end
      8'd30:   begin mult = 4'd2;  due = MULT_MASK_30[minute_adv]; end
      default: begin mult = 4'd1;  due = MULT_MASK_60[minute_adv]; end
    endcase
  end

  always_comb begin
    action      = ACT_REPORT;
    minute_next = minute_adv;
    last_next   = last_cur;
    last_we     = 1'b0;
    if (!in_range) begin
      action = ACT_OUT_OF_RANGE;
    end else if (enable_mask[s0_item.channel]) begin
      if (s0_item.clear_max) begin
        action    = ACT_CLEAR;
        last_next = '0;
        last_we   = 1'b1;
      end else if (n != 8'd0) begin
        if (last_cur == 32'd0) begin
          last_next = s0_item.count;
          last_we   = 1'b1;
        end else begin
          if (due) begin
            if (s0_item.count >= last_cur) begin
              action = ACT_COMPUTE;
            end
            last_next = s0_item.count;
            last_we   = 1'b1;
          end
          // daily resynchronisation
          if (s0_item.stamp.hour == RESYNC_HOUR && s0_item.stamp.minute == RESYNC_MINUTE) begin
            minute_next = RESYNC_MINUTE_VAL;
            last_next   = s0_item.count;
            last_we     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_counter <= MINUTE_UNSET;
      for (int i = 0; i < CHANNELS; i++) begin
        last_count[i] <= '0;
      end
    end else if (advance && s0_valid) begin
      minute_counter <= minute_next;
      if (last_we) begin
        last_count[ch_idx] <= last_next;
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Stages 2 to 4: scale by 60/n and divide by 1000
  logic [32:0] shifted;
  logic [15:0] split_hi;
  logic [16:0] split_lo;
  logic [31:0] quot_hi_full;
  logic [22:0] rem_next;
  logic [46:0] recip_prod;
  logic [15:0] quot_lo;

  assign shifted      = s2_prod[35:DIV_PRESHIFT];
  assign split_hi     = shifted[32:DIV_SPLIT];
  assign split_lo     = shifted[DIV_SPLIT-1:0];
  assign quot_hi_full = 32'(split_hi) * 32'(SPLIT_QUOT);
  assign rem_next     = 23'(23'(split_hi) * 23'(SPLIT_REM)) + 23'(split_lo);
  assign recip_prod   = 47'(s3_rem) * 47'(RECIP_125);
  assign quot_lo      = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_action  <= action;
      s1_ch      <= ch_idx;
      s1_stamp   <= s0_item.stamp;
      s1_diff    <= s0_item.count - last_cur;
      s1_mult    <= mult;

      s2_action  <= s1_action;
      s2_ch      <= s1_ch;
      s2_stamp   <= s1_stamp;
      s2_prod    <= 36'(s1_diff) * 36'(s1_mult);

      s3_action  <= s2_action;
      s3_ch      <= s2_ch;
      s3_stamp   <= s2_stamp;
      s3_quot_hi <= quot_hi_full[15:0];
      s3_rem     <= rem_next;

      s4_action  <= s3_action;
      s4_ch      <= s3_ch;
      s4_stamp   <= s3_stamp;
      s4_mean    <= s3_quot_hi + quot_lo;
    end
  end

  // Stage 5: mean and maximum stores, result register
  logic [15:0] mean_new;
  logic [15:0] max_new;
  stamp_t      stamp_new;
  logic        store_we;
  logic        new_max_flag;
  logic        cleared_flag;

  always_comb begin
    mean_new     = mean_store[s4_ch];
    max_new      = max_store[s4_ch];
    stamp_new    = max_stamp[s4_ch];
    store_we     = 1'b0;
    new_max_flag = 1'b0;
    cleared_flag = 1'b0;
    case (s4_action)
      ACT_CLEAR: begin
        mean_new     = '0;
        max_new      = '0;
        stamp_new    = STAMP_CLEAR;
        store_we     = 1'b1;
        cleared_flag = 1'b1;
      end
      ACT_COMPUTE: begin
        mean_new = s4_mean;
        store_we = 1'b1;
        if (s4_mean > max_store[s4_ch]) begin
          max_new      = s4_mean;
          stamp_new    = s4_stamp;
          new_max_flag = 1'b1;
        end
      end
      ACT_OUT_OF_RANGE: begin
        mean_new  = '0;
        max_new   = '0;
        stamp_new = STAMP_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mean_store[i] <= '0;
        max_store[i]  <= '0;
        max_stamp[i]  <= STAMP_CLEAR;
      end
    end else if (advance && s4_valid && store_we) begin
      mean_store[s4_ch] <= mean_new;
      max_store[s4_ch]  <= max_new;
      max_stamp[s4_ch]  <= stamp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mean_power <= mean_new;
      max_power  <= max_new;
      max_year   <= stamp_new.year;
      max_month  <= stamp_new.month;
      max_day    <= stamp_new.day;
      max_hour   <= stamp_new.hour;
      max_minute <= stamp_new.minute;
      new_max    <= new_max_flag;
      cleared    <= cleared_flag;
    end
  end

endmodule

>>> tb/mpmd_demand_checker.sv
// Checker for the mean power / maximum demand unit: watches the channels, predicts and compares.
`timescale 1ns / 1ps

module mpmd_demand_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mpmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           item_valid,
  input  logic                           item_ready,
  input  logic [1:0]                     channel,
  input  logic                           first_of_minute,
  input  logic [31:0]                    count,
  input  logic                           clear_max,
  input  logic [5:0]                     clock_minute,
  input  logic [4:0]                     clock_hour,
  input  logic [4:0]                     clock_day,
  input  logic [3:0]                     clock_month,
  input  logic [6:0]                     clock_year,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  logic [15:0]                    mean_power,
  input  logic [15:0]                    max_power,
  input  logic [6:0]                     max_year,
  input  logic [3:0]                     max_month,
  input  logic [4:0]                     max_day,
  input  logic [4:0]                     max_hour,
  input  logic [5:0]                     max_minute,
  input  logic                           new_max,
  input  logic                           cleared,
  input  logic                           end_of_test,
  output int                             fails,
  output int                             outstanding,
  output int                             checked
);
  import mpmd_pkg::*;

  localparam logic [63:0] WH_PER_KWH = 64'd1000;

  typedef struct packed {
    logic [15:0] mean_kw;
    logic [15:0] peak_kw;
    stamp_t      peak_at;
    logic        fresh_peak;
    logic        wiped;
  } demand_t;

  logic [CHANNELS-1:0] en_mask;
  logic [7:0]          interval_min [CHANNELS];
  logic [7:0]          minute_cnt;
  logic [31:0]         last_cnt [CHANNELS];
  logic [15:0]         mean_kw [CHANNELS];
  logic [15:0]         peak_kw [CHANNELS];
  stamp_t              peak_at [CHANNELS];
  demand_t             demand_q [$];
  bit                  wrapped_up = 1'b0;

  initial begin
    fails       = 0;
    checked     = 0;
    outstanding = 0;
  end

  task automatic report_fail(input string msg);
    $display("[%0t] demand check: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_fail($sformatf("result %0d %s = %0d, expected %0d", checked, name, got, want));
  endtask

  // Advance the minute counter, update the addressed channel and return what it reports.
  function automatic demand_t predict_demand(input logic [1:0] ch, input logic tick,
                                             input logic [31:0] cnt, input logic clr,
                                             input stamp_t now);
    demand_t     r;
    logic [7:0]  n;
    logic [31:0] delta;
    logic [63:0] scaled;
    r.fresh_peak = 1'b0;
    r.wiped      = 1'b0;
    if (tick) begin
      if (minute_cnt == MINUTE_UNSET) begin
        minute_cnt = {2'b00, now.minute};
      end else begin
        minute_cnt = minute_cnt + 8'd1;
        if (minute_cnt >= MINUTES_PER_HOUR) minute_cnt = '0;
      end
    end
    if (en_mask[ch]) begin
      n = interval_min[ch];
      if (clr) begin
        mean_kw[ch]  = '0;
        peak_kw[ch]  = '0;
        peak_at[ch]  = STAMP_CLEAR;
        last_cnt[ch] = '0;
        r.wiped      = 1'b1;
      end else if (n != 0) begin
        case (n)
          8'd5, 8'd10, 8'd15, 8'd20, 8'd30, 8'd60: ;
          default: n = MINUTES_PER_HOUR;
        endcase
        if (last_cnt[ch] == 0) begin
          last_cnt[ch] = cnt;
        end else begin
          if (minute_cnt % n == 0) begin
            // a counter that went backwards keeps the old mean
            if (cnt >= last_cnt[ch]) begin
              delta       = cnt - last_cnt[ch];
              scaled      = 64'(delta) * 64'(MINUTES_PER_HOUR / n) / WH_PER_KWH;
              mean_kw[ch] = scaled[15:0];
              if (mean_kw[ch] > peak_kw[ch]) begin
                peak_kw[ch]  = mean_kw[ch];
                peak_at[ch]  = now;
                r.fresh_peak = 1'b1;
              end
            end
            last_cnt[ch] = cnt;
          end
          // daily resync comes after the computation
          if (now.hour == RESYNC_HOUR && now.minute == RESYNC_MINUTE) begin
            minute_cnt   = RESYNC_MINUTE_VAL;
            last_cnt[ch] = cnt;
          end
        end
      end
    end
    r.mean_kw = mean_kw[ch];
    r.peak_kw = peak_kw[ch];
    r.peak_at = peak_at[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    demand_t want;
    if (rst) begin
      en_mask    = '0;
      minute_cnt = MINUTE_UNSET;
      for (int c = 0; c < CHANNELS; c++) begin
        interval_min[c] = MINUTES_PER_HOUR;
        last_cnt[c]     = '0;
        mean_kw[c]      = '0;
        peak_kw[c]      = '0;
        peak_at[c]      = STAMP_CLEAR;
      end
      demand_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE_MASK: en_mask         = cfg_data[CHANNELS-1:0];
          REG_INTERVAL_0:  interval_min[0] = cfg_data;
          REG_INTERVAL_1:  interval_min[1] = cfg_data;
          REG_INTERVAL_2:  interval_min[2] = cfg_data;
          REG_INTERVAL_3:  interval_min[3] = cfg_data;
          default: ;
        endcase
      end
      // take the result before queueing this edge's item
      if (result_valid && result_ready) begin
        if (demand_q.size() == 0) begin
          report_fail("result transaction with nothing outstanding");
        end else begin
          want = demand_q.pop_front();
          check_field("mean_power", mean_power, want.mean_kw);
          check_field("max_power", max_power, want.peak_kw);
          check_field("max_year", max_year, want.peak_at.year);
          check_field("max_month", max_month, want.peak_at.month);
          check_field("max_day", max_day, want.peak_at.day);
          check_field("max_hour", max_hour, want.peak_at.hour);
          check_field("max_minute", max_minute, want.peak_at.minute);
          check_field("new_max", new_max, want.fresh_peak);
          check_field("cleared", cleared, want.wiped);
          checked++;
        end
      end
      if (item_valid && item_ready)
        demand_q.push_back(predict_demand(channel, first_of_minute, count, clear_max,
                           {clock_year, clock_month, clock_day, clock_hour, clock_minute}));
      if (end_of_test && !wrapped_up) begin
        wrapped_up = 1'b1;
        if (demand_q.size() != 0)
          report_fail($sformatf("%0d results never arrived", demand_q.size()));
      end
    end
    outstanding <= demand_q.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top of the mean power / maximum demand unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
  import mpmd_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [1:0]           channel = '0;
  logic                 first_of_minute = 1'b0;
  logic [31:0]          count = '0;
  logic                 clear_max = 1'b0;
  logic [5:0]           clock_minute = '0;
  logic [4:0]           clock_hour = '0;
  logic [4:0]           clock_day = 5'd1;
  logic [3:0]           clock_month = 4'd1;
  logic [6:0]           clock_year = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [15:0]          mean_power;
  logic [15:0]          max_power;
  logic [6:0]           max_year;
  logic [3:0]           max_month;
  logic [4:0]           max_day;
  logic [4:0]           max_hour;
  logic [5:0]           max_minute;
  logic                 new_max;
  logic                 cleared;
  logic                 end_of_test = 1'b0;

  int          fails;
  int          outstanding;
  int          checked;
  int          cycles = 0;
  int          sent = 0;
  int          cfg_writes = 0;
  int          settings = 0;
  int          rdy_left = 0;
  bit          rdy_calm = 1'b0;
  bit          gapless = 1'b0;
  int          wmin, whour, wday, wmon, wyear;
  logic [31:0] meter [CHANNELS];

  mean_power_max_demand_unit dut (.*);

  mpmd_demand_checker demand_chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: bursts of ready, short and occasional long stalls, calm stretches.
  always @(posedge clk) begin
    if (rdy_left > 0) begin
      rdy_left--;
    end else if (result_ready) begin
      if (rdy_calm) begin
        rdy_left = $urandom_range(20, 120);
      end else begin
        result_ready <= 1'b0;
        rdy_left = stall_len();
      end
      if ($urandom_range(0, 9) == 0) rdy_calm = !rdy_calm;
    end else begin
      result_ready <= 1'b1;
      rdy_left = $urandom_range(0, 12);
    end
  end

  function automatic item_t wall_item(input logic [1:0] ch, input logic tick,
                                      input logic [31:0] cnt, input logic clr);
    item_t it;
    it.channel         = ch;
    it.first_of_minute = tick;
    it.count           = cnt;
    it.clear_max       = clr;
    it.stamp.year      = 7'(wyear);
    it.stamp.month     = 4'(wmon);
    it.stamp.day       = 5'(wday);
    it.stamp.hour      = 5'(whour);
    it.stamp.minute    = 6'(wmin);
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t       it;
    logic [31:0] raw;
    raw                = $urandom;
    it.channel         = raw[1:0];
    it.first_of_minute = raw[2];
    it.clear_max       = ($urandom_range(0, 15) == 0);
    it.count           = $urandom;
    raw                = $urandom;
    it.stamp           = raw[26:0];
    return it;
  endfunction

  task automatic pause_sender(input int n);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold valid and payload until the transaction is taken.
  task automatic send_item(input item_t it);
    pause_sender((gapless || $urandom_range(0, 1) == 0) ? 0 : stall_len());
    item_valid      <= 1'b1;
    channel         <= it.channel;
    first_of_minute <= it.first_of_minute;
    count           <= it.count;
    clear_max       <= it.clear_max;
    clock_minute    <= it.stamp.minute;
    clock_hour      <= it.stamp.hour;
    clock_day       <= it.stamp.day;
    clock_month     <= it.stamp.month;
    clock_year      <= it.stamp.year;
    do @(posedge clk); while (!item_ready);
    sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] mask, input logic [7:0] i0,
                              input logic [7:0] i1, input logic [7:0] i2,
                              input logic [7:0] i3);
    int r;
    for (r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      case (r)
        0: begin cfg_index <= REG_ENABLE_MASK; cfg_data <= {4'b0000, mask}; end
        1: begin cfg_index <= REG_INTERVAL_0;  cfg_data <= i0; end
        2: begin cfg_index <= REG_INTERVAL_1;  cfg_data <= i1; end
        3: begin cfg_index <= REG_INTERVAL_2;  cfg_data <= i2; end
        default: begin cfg_index <= REG_INTERVAL_3; cfg_data <= i3; end
      endcase
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      case ($urandom_range(0, 5))
        0: return 8'd5;
        1: return 8'd10;
        2: return 8'd15;
        3: return 8'd20;
        4: return 8'd30;
        default: return 8'd60;
      endcase
    end
    if (r < 87) return 8'd0;
    if (r < 92) return 8'd255;
    return 8'($urandom_range(1, 254));
  endfunction

  // One wall-clock minute: the first report of the minute carries the tick.
  task automatic run_minute();
    item_t      it;
    int         reports;
    int         first_ch;
    int         k;
    int         r;
    logic [1:0] ch;
    wmin++;
    if (wmin >= 60) begin
      wmin = 0;
      whour++;
      if (whour == 24) begin
        whour = 0;
        wday++;
        if (wday == 32) begin
          wday = 1;
          wmon++;
          if (wmon == 13) begin
            wmon  = 1;
            wyear = (wyear + 1) % 100;
          end
        end
      end
    end
    reports  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : CHANNELS;
    first_ch = $urandom_range(0, CHANNELS - 1);
    for (k = 0; k < reports; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(noise_item());
      ch = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'((first_ch + k) % CHANNELS);
      r  = $urandom_range(0, 99);
      if (r < 3)       meter[ch] = meter[ch] - $urandom_range(1, 200000);
      else if (r < 8)  meter[ch] = meter[ch] + $urandom;
      else if (r < 10) meter[ch] = '0;
      else             meter[ch] = meter[ch] + $urandom_range(0, 400000);
      send_item(wall_item(ch, k == 0, meter[ch], $urandom_range(0, 49) == 0));
    end
  endtask

  initial begin
    int          directed_sent;
    int          phase;
    int          minutes;
    int          m;
    logic [3:0]  mask;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: minute counter loaded past 59, priming, backwards counter, truncation,
    // zero and invalid intervals, clear, resync at 04:01, disabled channels.
    program_regs(4'hF, 8'd5, 8'd60, 8'd0, 8'd255);
    wyear = 99; wmon = 12; wday = 31; whour = 23; wmin = 62;
    send_item(wall_item(2'd0, 1'b1, 32'd1000, 1'b0));
    send_item(wall_item(2'd1, 1'b0, 32'd0, 1'b0));
    wmin = 63;
    send_item(wall_item(2'd0, 1'b1, 32'd501000, 1'b0));
    send_item(wall_item(2'd1, 1'b0, 32'hFFFF_FFFF, 1'b0));
    send_item(wall_item(2'd1, 1'b0, 32'd0, 1'b0));
    send_item(wall_item(2'd2, 1'b0, 32'd1234, 1'b0));
    send_item(wall_item(2'd2, 1'b0, 32'd1234, 1'b1));
    send_item(wall_item(2'd3, 1'b0, 32'd5, 1'b0));
    send_item(wall_item(2'd3, 1'b0, 32'hFFFF_FFFF, 1'b0));
    wyear = 64; wmon = 1; wday = 1; whour = 0; wmin = 0;
    send_item(wall_item(2'd0, 1'b1, 32'd501100, 1'b0));
    whour = 4; wmin = 1;
    send_item(wall_item(2'd0, 1'b0, 32'd501200, 1'b0));
    send_item(wall_item(2'd0, 1'b0, 32'd7, 1'b1));
    send_item(wall_item(2'd0, 1'b0, 32'd0, 1'b0));
    send_item(wall_item(2'd3, 1'b0, 32'd9, 1'b1));
    wait_drained();
    program_regs(4'b0101, 8'd10, 8'd15, 8'd20, 8'd30);
    send_item(wall_item(2'd1, 1'b0, 32'd77, 1'b1));
    send_item(wall_item(2'd3, 1'b1, 32'd7, 1'b0));
    send_item(wall_item(2'd0, 1'b0, 32'd100, 1'b0));
    send_item(wall_item(2'd2, 1'b0, 32'd55, 1'b0));
    wait_drained();
    program_regs(4'h0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(wall_item(2'd0, 1'b1, 32'd1000, 1'b1));
    send_item(wall_item(2'd2, 1'b0, 32'hFFFF_FFFF, 1'b0));
    directed_sent = sent;

    for (int c = 0; c < CHANNELS; c++) meter[c] = $urandom;
    for (phase = 0; sent < directed_sent + RANDOM_ITEMS; phase++) begin
      wait_drained();
      mask = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom);
      program_regs(mask, pick_interval(), pick_interval(), pick_interval(), pick_interval());
      wyear = $urandom_range(0, 99);
      wmon  = $urandom_range(1, 12);
      wday  = $urandom_range(1, 31);
      if (phase == 0) begin
        // walk through 04:01 for the daily resync
        whour   = 3;
        wmin    = 50;
        minutes = 16;
      end else begin
        whour   = $urandom_range(0, 23);
        wmin    = $urandom_range(0, 59);
        minutes = $urandom_range(8, 20);
      end
      gapless = ($urandom_range(0, 2) == 0);
      for (m = 0; m < minutes; m++) begin
        if (phase == 1 && m == minutes / 2) wait_drained();
        run_minute();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Covered %0d items (%0d directed) over %0d register settings, %0d register writes",
             sent, directed_sent, settings, cfg_writes);
    $display("%0d results checked, %0d mismatches, %0d cycles", checked, fails, cycles);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
design/mpmd_pkg.sv
design/mean_power_max_demand_unit.sv
tb/mpmd_demand_checker.sv
tb/tb.sv
